FILE: rtl/dtmp_pkg.sv
package dtmp_pkg;

  // Name length limit in characters, dots included
  localparam int unsigned MaxNameChars = 128;
  // Address bytes emitted from an AAAA answer
  localparam int unsigned AddrBytes    = 16;
  localparam int unsigned AddrCntW     = $clog2(AddrBytes + 1);

  // Body offsets (after the length prefix)
  localparam logic [15:0] AncountHiPos = 16'd6;
  localparam logic [15:0] AncountLoPos = 16'd7;
  localparam logic [15:0] NameLastHdr  = 16'd11;

  localparam logic [7:0] TypeAaaa      = 8'd28;
  localparam logic [7:0] MaxLabel      = 8'd63;
  localparam logic [7:0] DotChar       = 8'd46;
  localparam logic [3:0] QToAnswerType = 4'd6;
  localparam logic [3:0] ATypeToLen    = 4'd6;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhLenLo   = 4'd1,
    PhHeader  = 4'd2,
    PhNameLen = 4'd3,
    PhLabel   = 4'd4,
    PhQtypeHi = 4'd5,
    PhQtypeLo = 4'd6,
    PhSkipQ   = 4'd7,
    PhAtypeHi = 4'd8,
    PhAtypeLo = 4'd9,
    PhSkipA   = 4'd10,
    PhDlenHi  = 4'd11,
    PhDlenLo  = 4'd12,
    PhAddr    = 4'd13,
    PhDone    = 4'd14
  } phase_e;

  // One result item
  typedef struct packed {
    logic       name_char_valid;
    logic [7:0] name_char;
    logic       name_end;
    logic       query_is_aaaa;
    logic       query_unimplemented;
    logic       no_answers;
    logic       answer_is_aaaa;
    logic       addr_valid;
    logic [7:0] addr_byte;
    logic       message_end;
    logic       malformed;
  } res_t;

endpackage

FILE: rtl/dtmp_parse_core.sv
module dtmp_parse_core #(
  parameter int unsigned MaxNameChars = dtmp_pkg::MaxNameChars
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           is_response_i,
  output dtmp_pkg::res_t res_o
);
  import dtmp_pkg::*;

  phase_e               phase_q, phase_d;
  logic [15:0]          pos_q, pos_d;
  logic [15:0]          len_q, len_d;
  logic [5:0]           label_q, label_d;
  logic [7:0]           name_cnt_q, name_cnt_d;
  logic                 resp_q, resp_d;
  logic [3:0]           skip_q, skip_d;
  logic [7:0]           hi_q, hi_d;
  logic [AddrCntW-1:0]  addr_q, addr_d;

  logic        last;
  logic        in_body;
  logic        name_full;
  logic [15:0] len_new;
  logic [15:0] dlen;
  logic [5:0]  label_dec;
  logic [3:0]  skip_dec;
  logic [AddrCntW-1:0] addr_dec;
  logic        type_match;

  // Shared decode
  assign len_new    = {hi_q, data_byte_i};
  assign dlen       = {hi_q, data_byte_i};
  assign last       = ({1'b0, pos_q} + 17'd1) == {1'b0, len_q};
  assign in_body    = (phase_q != PhIdle) && (phase_q != PhLenLo);
  assign name_full  = name_cnt_q >= 8'(MaxNameChars);
  assign label_dec  = label_q - 6'd1;
  assign skip_dec   = skip_q - 4'd1;
  assign addr_dec   = addr_q - AddrCntW'(1);
  assign type_match = (hi_q == 8'd0) && (data_byte_i == TypeAaaa);

  // Next state
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    len_d      = len_q;
    label_d    = label_q;
    name_cnt_d = name_cnt_q;
    resp_d     = resp_q;
    skip_d     = skip_q;
    hi_d       = hi_q;
    addr_d     = addr_q;
    case (phase_q)
      PhIdle: begin
        resp_d  = is_response_i;
        hi_d    = data_byte_i;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d      = len_new;
        pos_d      = '0;
        label_d    = '0;
        name_cnt_d = '0;
        skip_d     = '0;
        addr_d     = '0;
        hi_d       = '0;
        phase_d    = (len_new == 16'd0) ? PhIdle : PhHeader;
      end
      PhHeader: begin
        if (pos_q == AncountHiPos) begin
          hi_d = data_byte_i;
        end else if (pos_q == AncountLoPos && resp_q && hi_q == 8'd0 &&
                     data_byte_i == 8'd0) begin
          phase_d = PhDone;
        end else if (pos_q == NameLastHdr) begin
          phase_d = PhNameLen;
        end
      end
      PhNameLen: begin
        if (data_byte_i == 8'd0) begin
          if (resp_q) begin
            skip_d  = QToAnswerType;
            phase_d = PhSkipQ;
          end else begin
            phase_d = PhQtypeHi;
          end
        end else if (data_byte_i > MaxLabel) begin
          phase_d = PhDone;
        end else if (name_cnt_q != 8'd0 && name_full) begin
          phase_d = PhDone;
        end else begin
          if (name_cnt_q != 8'd0) begin
            name_cnt_d = name_cnt_q + 8'd1;
          end
          label_d = data_byte_i[5:0];
          phase_d = PhLabel;
        end
      end
      PhLabel: begin
        if (name_full) begin
          phase_d = PhDone;
        end else begin
          name_cnt_d = name_cnt_q + 8'd1;
          label_d    = label_dec;
          if (label_dec == 6'd0) begin
            phase_d = PhNameLen;
          end
        end
      end
      PhQtypeHi: begin
        hi_d    = data_byte_i;
        phase_d = PhQtypeLo;
      end
      PhQtypeLo: phase_d = PhDone;
      PhSkipQ: begin
        skip_d = skip_dec;
        if (skip_dec == 4'd0) begin
          phase_d = PhAtypeHi;
        end
      end
      PhAtypeHi: begin
        hi_d    = data_byte_i;
        phase_d = PhAtypeLo;
      end
      PhAtypeLo: begin
        if (type_match) begin
          skip_d  = ATypeToLen;
          phase_d = PhSkipA;
        end else begin
          phase_d = PhDone;
        end
      end
      PhSkipA: begin
        skip_d = skip_dec;
        if (skip_dec == 4'd0) begin
          phase_d = PhDlenHi;
        end
      end
      PhDlenHi: begin
        hi_d    = data_byte_i;
        phase_d = PhDlenLo;
      end
      PhDlenLo: begin
        if (dlen > 16'(AddrBytes)) begin
          addr_d = AddrCntW'(AddrBytes);
        end else begin
          addr_d = dlen[AddrCntW-1:0];
        end
        phase_d = (dlen == 16'd0) ? PhDone : PhAddr;
      end
      PhAddr: begin
        addr_d = addr_dec;
        if (addr_dec == '0) begin
          phase_d = PhDone;
        end
      end
      default: phase_d = PhDone;
    endcase

    // Message framing overrides the phase on the last body byte
    if (in_body) begin
      if (last) begin
        phase_d = PhIdle;
        pos_d   = '0;
      end else begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  // Result item
  always_comb begin
    res_o = '0;
    case (phase_q)
      PhLenLo: res_o.message_end = (len_new == 16'd0);
      PhHeader: begin
        res_o.no_answers = (pos_q == AncountLoPos) && resp_q && (hi_q == 8'd0) &&
                           (data_byte_i == 8'd0);
      end
      PhNameLen: begin
        if (data_byte_i == 8'd0) begin
          res_o.name_end = 1'b1;
        end else if (data_byte_i > MaxLabel) begin
          res_o.malformed = 1'b1;
        end else if (name_cnt_q != 8'd0) begin
          if (name_full) begin
            res_o.malformed = 1'b1;
          end else begin
            res_o.name_char_valid = 1'b1;
            res_o.name_char       = DotChar;
          end
        end
      end
      PhLabel: begin
        if (name_full) begin
          res_o.malformed = 1'b1;
        end else begin
          res_o.name_char_valid = 1'b1;
          res_o.name_char       = data_byte_i;
        end
      end
      PhQtypeLo: begin
        res_o.query_is_aaaa       = type_match;
        res_o.query_unimplemented = !type_match;
      end
      PhAtypeLo: res_o.answer_is_aaaa = type_match;
      PhAddr: begin
        res_o.addr_valid = 1'b1;
        res_o.addr_byte  = data_byte_i;
      end
      default: res_o = '0;
    endcase
    if (in_body && last) begin
      res_o.message_end = 1'b1;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      pos_q      <= '0;
      len_q      <= '0;
      label_q    <= '0;
      name_cnt_q <= '0;
      resp_q     <= 1'b0;
      skip_q     <= '0;
      hi_q       <= '0;
      addr_q     <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      label_q    <= label_d;
      name_cnt_q <= name_cnt_d;
      resp_q     <= resp_d;
      skip_q     <= skip_d;
      hi_q       <= hi_d;
      addr_q     <= addr_d;
    end
  end

endmodule

FILE: rtl/dtmp_out_reg.sv
module dtmp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dtmp_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dtmp_pkg::res_t res_o
);
  import dtmp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;
  logic load;

  // Takes a new result whenever the held one is gone or leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/dns_tcp_message_parser.sv
// DNS-over-TCP message parser. Feed the TCP stream one byte per transfer,
// the 2-byte length prefix included; is_response_i is sampled with the first
// prefix byte. Every input byte yields exactly one result item: the question
// name streamed as characters with dots, query type and answer checks, up to
// 16 AAAA address bytes, end-of-message and malformed flags. The parser state
// updates in the cycle a byte is taken and the result lands in an output
// register, so one byte per cycle is sustained; the only stall is the output
// register when its result is not taken.
module dns_tcp_message_parser #(
  parameter int unsigned MaxNameChars = dtmp_pkg::MaxNameChars
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_response_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       name_char_valid_o,
  output logic [7:0] name_char_o,
  output logic       name_end_o,
  output logic       query_is_aaaa_o,
  output logic       query_unimplemented_o,
  output logic       no_answers_o,
  output logic       answer_is_aaaa_o,
  output logic       addr_valid_o,
  output logic [7:0] addr_byte_o,
  output logic       message_end_o,
  output logic       malformed_o
);
  import dtmp_pkg::*;

  res_t res_comb;
  res_t res_out;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  dtmp_parse_core #(
    .MaxNameChars (MaxNameChars)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .is_response_i (is_response_i),
    .res_o         (res_comb)
  );

  dtmp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_i       (res_comb),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign name_char_valid_o     = res_out.name_char_valid;
  assign name_char_o           = res_out.name_char;
  assign name_end_o            = res_out.name_end;
  assign query_is_aaaa_o       = res_out.query_is_aaaa;
  assign query_unimplemented_o = res_out.query_unimplemented;
  assign no_answers_o          = res_out.no_answers;
  assign answer_is_aaaa_o      = res_out.answer_is_aaaa;
  assign addr_valid_o          = res_out.addr_valid;
  assign addr_byte_o           = res_out.addr_byte;
  assign message_end_o         = res_out.message_end;
  assign malformed_o           = res_out.malformed;

endmodule

FILE: bench/dtmp_checker.sv
module dtmp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_response_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        name_char_valid_i,
  input  logic [7:0]  name_char_i,
  input  logic        name_end_i,
  input  logic        query_is_aaaa_i,
  input  logic        query_unimplemented_i,
  input  logic        no_answers_i,
  input  logic        answer_is_aaaa_i,
  input  logic        addr_valid_i,
  input  logic [7:0]  addr_byte_i,
  input  logic        message_end_i,
  input  logic        malformed_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import dtmp_pkg::*;

  // Parser state mirror
  phase_e      phase;
  logic [15:0] body_pos;
  logic [15:0] msg_len;
  logic [5:0]  label_left;
  logic [7:0]  name_len;
  logic        resp_mode;
  logic [3:0]  skip_left;
  logic [7:0]  held_byte;
  logic [15:0] addr_left;

  res_t        parsed_q[$];
  int unsigned mismatches = 0;
  int unsigned waiting = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic reset_parser();
    phase      = PhIdle;
    body_pos   = '0;
    msg_len    = '0;
    label_left = '0;
    name_len   = '0;
    resp_mode  = 1'b0;
    skip_left  = '0;
    held_byte  = '0;
    addr_left  = '0;
  endtask

  // Advance the parser mirror by one stream byte and return its result
  task automatic parse_byte(input logic [7:0] b, input logic resp, output res_t r);
    logic        last;
    logic [15:0] dlen;
    r = '0;
    if (phase == PhIdle) begin
      resp_mode = resp;
      held_byte = b;
      phase     = PhLenLo;
    end else if (phase == PhLenLo) begin
      msg_len    = {held_byte, b};
      body_pos   = '0;
      label_left = '0;
      name_len   = '0;
      skip_left  = '0;
      addr_left  = '0;
      held_byte  = '0;
      if (msg_len == 16'd0) begin
        r.message_end = 1'b1;
        phase = PhIdle;
      end else begin
        phase = PhHeader;
      end
    end else begin
      last = ({1'b0, body_pos} + 17'd1) == {1'b0, msg_len};
      case (phase)
        PhHeader: begin
          if (body_pos == AncountHiPos) begin
            held_byte = b;
          end else if (body_pos == AncountLoPos && resp_mode &&
                       held_byte == 8'd0 && b == 8'd0) begin
            r.no_answers = 1'b1;
            phase = PhDone;
          end
          if (phase == PhHeader && body_pos == NameLastHdr) phase = PhNameLen;
        end
        PhNameLen: begin
          if (b == 8'd0) begin
            r.name_end = 1'b1;
            if (resp_mode) begin
              skip_left = QToAnswerType;
              phase = PhSkipQ;
            end else begin
              phase = PhQtypeHi;
            end
          end else if (b > MaxLabel) begin
            r.malformed = 1'b1;
            phase = PhDone;
          end else if (name_len != 8'd0) begin
            if (name_len >= MaxNameChars) begin
              r.malformed = 1'b1;
              phase = PhDone;
            end else begin
              r.name_char_valid = 1'b1;
              r.name_char = DotChar;
              name_len++;
              label_left = b[5:0];
              phase = PhLabel;
            end
          end else begin
            label_left = b[5:0];
            phase = PhLabel;
          end
        end
        PhLabel: begin
          if (name_len >= MaxNameChars) begin
            r.malformed = 1'b1;
            phase = PhDone;
          end else begin
            r.name_char_valid = 1'b1;
            r.name_char = b;
            name_len++;
            label_left = label_left - 6'd1;
            if (label_left == 6'd0) phase = PhNameLen;
          end
        end
        PhQtypeHi: begin
          held_byte = b;
          phase = PhQtypeLo;
        end
        PhQtypeLo: begin
          if (held_byte == 8'd0 && b == TypeAaaa) r.query_is_aaaa = 1'b1;
          else r.query_unimplemented = 1'b1;
          phase = PhDone;
        end
        PhSkipQ: begin
          skip_left = skip_left - 4'd1;
          if (skip_left == 4'd0) phase = PhAtypeHi;
        end
        PhAtypeHi: begin
          held_byte = b;
          phase = PhAtypeLo;
        end
        PhAtypeLo: begin
          if (held_byte == 8'd0 && b == TypeAaaa) begin
            r.answer_is_aaaa = 1'b1;
            skip_left = ATypeToLen;
            phase = PhSkipA;
          end else begin
            phase = PhDone;
          end
        end
        PhSkipA: begin
          skip_left = skip_left - 4'd1;
          if (skip_left == 4'd0) phase = PhDlenHi;
        end
        PhDlenHi: begin
          held_byte = b;
          phase = PhDlenLo;
        end
        PhDlenLo: begin
          dlen = {held_byte, b};
          addr_left = (dlen > AddrBytes) ? 16'(AddrBytes) : dlen;
          phase = (addr_left != 16'd0) ? PhAddr : PhDone;
        end
        PhAddr: begin
          r.addr_valid = 1'b1;
          r.addr_byte = b;
          addr_left = addr_left - 16'd1;
          if (addr_left == 16'd0) phase = PhDone;
        end
        default: phase = PhDone;
      endcase
      if (last) begin
        r.message_end = 1'b1;
        phase = PhIdle;
        body_pos = '0;
      end else begin
        body_pos = body_pos + 16'd1;
      end
    end
  endtask

  // Compare results first: a result can never come from this edge's byte
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      reset_parser();
      parsed_q.delete();
      waiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (parsed_q.size() == 0) begin
          report_mismatch("unexpected result", 8'd1, 8'd0);
        end else begin
          want = parsed_q.pop_front();
          check_field("name_char_valid", 8'(name_char_valid_i),
                      8'(want.name_char_valid));
          check_field("name_char", name_char_i, want.name_char);
          check_field("name_end", 8'(name_end_i), 8'(want.name_end));
          check_field("query_is_aaaa", 8'(query_is_aaaa_i), 8'(want.query_is_aaaa));
          check_field("query_unimplemented", 8'(query_unimplemented_i),
                      8'(want.query_unimplemented));
          check_field("no_answers", 8'(no_answers_i), 8'(want.no_answers));
          check_field("answer_is_aaaa", 8'(answer_is_aaaa_i),
                      8'(want.answer_is_aaaa));
          check_field("addr_valid", 8'(addr_valid_i), 8'(want.addr_valid));
          check_field("addr_byte", addr_byte_i, want.addr_byte);
          check_field("message_end", 8'(message_end_i), 8'(want.message_end));
          check_field("malformed", 8'(malformed_i), 8'(want.malformed));
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(data_byte_i, is_response_i, want);
        parsed_q.push_back(want);
      end
      waiting = unsigned'(parsed_q.size());
    end
  end

endmodule

FILE: bench/tb_dns_tcp_message_parser.sv
module tb_dns_tcp_message_parser;
  import dtmp_pkg::*;

  localparam logic [15:0] QtypeAaaa = {8'h00, TypeAaaa};
  localparam int unsigned RandBytes = 220;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       is_resp;
  logic       out_valid;
  logic       out_ready;
  logic       name_char_valid;
  logic [7:0] name_char;
  logic       name_end;
  logic       query_is_aaaa;
  logic       query_unimplemented;
  logic       no_answers;
  logic       answer_is_aaaa;
  logic       addr_valid;
  logic [7:0] addr_byte;
  logic       message_end;
  logic       malformed;

  int unsigned mismatches;
  int unsigned pending;

  // No-idle window for both sides
  bit          calm = 1'b0;
  int unsigned bytes_sent = 0;
  logic [7:0]  body_q[$];
  int          label_plan[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dns_tcp_message_parser u_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .data_byte_i           (data_byte),
    .is_response_i         (is_resp),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .name_char_valid_o     (name_char_valid),
    .name_char_o           (name_char),
    .name_end_o            (name_end),
    .query_is_aaaa_o       (query_is_aaaa),
    .query_unimplemented_o (query_unimplemented),
    .no_answers_o          (no_answers),
    .answer_is_aaaa_o      (answer_is_aaaa),
    .addr_valid_o          (addr_valid),
    .addr_byte_o           (addr_byte),
    .message_end_o         (message_end),
    .malformed_o           (malformed)
  );

  dtmp_checker u_parse_check (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_i            (in_ready),
    .data_byte_i           (data_byte),
    .is_response_i         (is_resp),
    .out_valid_i           (out_valid),
    .out_ready_i           (out_ready),
    .name_char_valid_i     (name_char_valid),
    .name_char_i           (name_char),
    .name_end_i            (name_end),
    .query_is_aaaa_i       (query_is_aaaa),
    .query_unimplemented_i (query_unimplemented),
    .no_answers_i          (no_answers),
    .answer_is_aaaa_i      (answer_is_aaaa),
    .addr_valid_i          (addr_valid),
    .addr_byte_i           (addr_byte),
    .message_end_i         (message_end),
    .malformed_i           (malformed),
    .errors_o              (mismatches),
    .pending_o             (pending)
  );

  // Result side: random stalls outside the calm window
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = calm || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // One byte transfer; returns right after the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic resp);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    is_resp   = resp;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Sender holds off until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Header, question name from label_plan, then query type or answer record
  task automatic build_body(input logic resp, input logic [15:0] ancount,
                            input logic [15:0] rtype, input logic [15:0] dlen);
    bit cut;
    int n_addr;
    cut = 1'b0;
    body_q.delete();
    for (int i = 0; i < 12; i++) body_q.push_back(rand_byte());
    body_q[6] = ancount[15:8];
    body_q[7] = ancount[7:0];
    foreach (label_plan[k]) begin
      if (!cut) begin
        body_q.push_back(8'(label_plan[k]));
        if (label_plan[k] > 63) cut = 1'b1;
        else for (int c = 0; c < label_plan[k]; c++) body_q.push_back(rand_byte());
      end
    end
    if (cut) begin
      for (int i = 0; i < 4; i++) body_q.push_back(rand_byte());
    end else begin
      body_q.push_back(8'd0);
      if (resp) begin
        // question type/class and compressed answer name
        for (int i = 0; i < 6; i++) body_q.push_back(rand_byte());
        body_q.push_back(rtype[15:8]);
        body_q.push_back(rtype[7:0]);
        for (int i = 0; i < 6; i++) body_q.push_back(rand_byte());
        body_q.push_back(dlen[15:8]);
        body_q.push_back(dlen[7:0]);
        n_addr = (dlen > 24) ? 24 : int'(dlen);
        for (int i = 0; i < n_addr; i++) body_q.push_back(rand_byte());
      end else begin
        body_q.push_back(rtype[15:8]);
        body_q.push_back(rtype[7:0]);
      end
    end
  endtask

  // Length prefix, then len bytes of the body, padded with noise if longer
  task automatic send_message(input logic resp, input logic [15:0] len);
    send_byte(len[15:8], resp);
    send_byte(len[7:0], 1'($urandom_range(1)));
    for (int i = 0; i < int'(len); i++) begin
      send_byte((i < body_q.size()) ? body_q[i] : rand_byte(), 1'($urandom_range(1)));
    end
  endtask

  task automatic send_built(input logic resp);
    send_message(resp, 16'(body_q.size()));
  endtask

  initial begin : stimulus
    int          r;
    int          msg_idx;
    int          n_labels;
    int unsigned rand_start;
    logic        resp;
    logic [15:0] ancount;
    logic [15:0] rtype;
    logic [15:0] dlen;
    logic [15:0] len;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    data_byte = 8'd0;
    is_resp   = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero-length message
    body_q.delete();
    send_message(1'b0, 16'd0);
    // AAAA query, other types, empty name
    label_plan = '{3, 7, 1};
    build_body(1'b0, 16'hffff, QtypeAaaa, 16'd0);
    send_built(1'b0);
    build_body(1'b0, 16'h0000, 16'h0001, 16'd0);
    send_built(1'b0);
    build_body(1'b0, 16'h0000, 16'h011c, 16'd0);
    send_built(1'b0);
    label_plan = {};
    build_body(1'b0, 16'h0001, QtypeAaaa, 16'd0);
    send_built(1'b0);
    // Oversized labels
    label_plan = '{5, 64};
    build_body(1'b0, 16'h0000, QtypeAaaa, 16'd0);
    send_built(1'b0);
    label_plan = '{255};
    build_body(1'b0, 16'h0000, QtypeAaaa, 16'd0);
    send_built(1'b0);
    // Name over the limit, inside a label and at a label length byte
    label_plan = '{63, 63, 2};
    build_body(1'b0, 16'h0000, QtypeAaaa, 16'd0);
    send_built(1'b0);
    label_plan = '{63, 62, 1, 5};
    build_body(1'b0, 16'h0000, QtypeAaaa, 16'd0);
    send_built(1'b0);
    // Responses: no answers, high count byte only, AAAA and other answers
    label_plan = '{2, 3};
    build_body(1'b1, 16'h0000, QtypeAaaa, 16'd16);
    send_built(1'b1);
    build_body(1'b1, 16'h0100, QtypeAaaa, 16'd16);
    send_built(1'b1);
    build_body(1'b1, 16'h0001, 16'h0001, 16'd16);
    send_built(1'b1);
    // Data length zero, over the address size, short
    build_body(1'b1, 16'h0001, QtypeAaaa, 16'd0);
    send_built(1'b1);
    build_body(1'b1, 16'h0002, QtypeAaaa, 16'd40);
    send_built(1'b1);
    build_body(1'b1, 16'h0001, QtypeAaaa, 16'd3);
    send_built(1'b1);
    // Truncated inside the header and inside the name; long trailer
    build_body(1'b1, 16'h0001, QtypeAaaa, 16'd16);
    send_message(1'b1, 16'd1);
    send_message(1'b0, 16'd16);
    send_message(1'b1, 16'(body_q.size() + 12));

    drain_results();

    // Random messages, mostly well formed
    rand_start = bytes_sent;
    msg_idx = 0;
    while (bytes_sent < rand_start + RandBytes) begin
      calm = (msg_idx >= 1 && msg_idx < 4);
      if (msg_idx == 4) drain_results();
      resp = 1'($urandom_range(1));

      label_plan = {};
      if ($urandom_range(99) < 4) begin
        repeat (4) label_plan.push_back($urandom_range(40, 63));
      end else begin
        n_labels = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 4);
        repeat (n_labels) begin
          r = $urandom_range(99);
          if (r < 5) label_plan.push_back(63);
          else if (r < 9) label_plan.push_back($urandom_range(64, 255));
          else label_plan.push_back($urandom_range(1, 12));
        end
      end

      r = $urandom_range(99);
      if (!resp) ancount = 16'($urandom_range(65535));
      else if (r < 20) ancount = 16'd0;
      else if (r < 30) ancount = {rand_byte(), 8'd0};
      else ancount = 16'($urandom_range(1, 3));

      r = $urandom_range(99);
      if (r < 50) rtype = QtypeAaaa;
      else if (r < 60) rtype = {rand_byte(), TypeAaaa};
      else if (r < 70) rtype = {8'd0, rand_byte()};
      else rtype = 16'($urandom_range(65535));

      r = $urandom_range(99);
      if (r < 55) dlen = 16'(AddrBytes);
      else if (r < 65) dlen = 16'd0;
      else if (r < 80) dlen = 16'($urandom_range(1, 15));
      else if (r < 90) dlen = 16'($urandom_range(17, 64));
      else dlen = 16'($urandom_range(65535));

      build_body(resp, ancount, rtype, dlen);

      r = $urandom_range(99);
      if (r < 3) len = 16'd0;
      else if (r < 15) len = 16'($urandom_range(1, body_q.size() - 1));
      else if (r < 27) len = 16'(body_q.size() + $urandom_range(1, 12));
      else len = 16'(body_q.size());
      send_message(resp, len);
      msg_idx++;
    end
    calm = 1'b0;

    drain_results();
    repeat (16) @(negedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
